### rtl/assert_macros.svh
// Assertion macros used by the record stack back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define VRS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define VRS_ASSERT(lbl, prop, msg)
`define VRS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/vrs_pkg.sv
// Types and codes shared by the record stack modules.
`default_nettype none
package vrs_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_PEEK  = 2'd1,
    OP_POP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_PUSHED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_PEEKED  = 3'd2,
    ST_POPPED  = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_CLEARED = 3'd5
  } status_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
    logic [6:0] record_length;
    logic       last_byte;
    logic [6:0] want_bytes;
  } cmd_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_out;
    logic       stack_empty;
  } res_t;

endpackage
`default_nettype wire

### rtl/vrs_req_if.sv
// Request channel interface: one stack operation per transaction.
`default_nettype none
interface vrs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [6:0] record_length;
  logic       last_byte;
  logic [6:0] want_bytes;

  modport source (output valid, kind, data_byte, record_length, last_byte, want_bytes,
                  input ready);
  modport sink   (input valid, kind, data_byte, record_length, last_byte, want_bytes,
                  output ready);
endinterface
`default_nettype wire

### rtl/vrs_rsp_if.sv
// Response channel interface: one result per transaction.
`default_nettype none
interface vrs_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_out;
  logic       stack_empty;

  modport source (output valid, status, out_byte, byte_valid, last_out, stack_empty,
                  input ready);
  modport sink   (input valid, status, out_byte, byte_valid, last_out, stack_empty,
                  output ready);
endinterface
`default_nettype wire

### rtl/vrs_front.sv
// Front end: accept request transactions, classify them and register the command.
`default_nettype none
module vrs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  vrs_req_if.sink       req_i,
  output vrs_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import vrs_pkg::*;

  logic valid_q;
  cmd_t cmd_q;
  cmd_t cmd_d;

  assign req_i.ready = !valid_q || cmd_ready_i;

  always_comb begin
    cmd_d.op            = op_e'(req_i.kind);
    cmd_d.data_byte     = req_i.data_byte;
    cmd_d.record_length = req_i.record_length;
    cmd_d.last_byte     = req_i.last_byte;
    cmd_d.want_bytes    = req_i.want_bytes;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = valid_q;
endmodule
`default_nettype wire

### rtl/vrs_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none
module vrs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vrs_pkg::cmd_t push_cmd_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output vrs_pkg::cmd_t pop_cmd_o,
  output logic          pop_valid_o,
  input  logic          pop_i
);
  import vrs_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end
endmodule
`default_nettype wire

### rtl/vrs_back.sv
// Back end: byte store, stack pointer, push sequencer and record read-out.
`default_nettype none
`include "assert_macros.svh"
module vrs_back #(
  parameter int STACK_BYTES = 1024,
  parameter int LEN_BYTES   = 4,
  parameter int MAX_RECORD  = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vrs_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  vrs_rsp_if.source     rsp_o
);
  import vrs_pkg::*;

  localparam int AW = $clog2(STACK_BYTES);
  localparam int TW = $clog2(STACK_BYTES + 1);
  localparam int XW = $clog2(STACK_BYTES + LEN_BYTES + MAX_RECORD + 1);
  localparam int LW = 8 * LEN_BYTES;
  localparam int SW = ((LW > TW) ? LW : TW) + 2;
  localparam int BW = (LEN_BYTES > 1) ? $clog2(LEN_BYTES) : 1;
  localparam logic [TW-1:0] STACK_T = TW'(STACK_BYTES);
  localparam logic [TW-1:0] LEN_T   = TW'(LEN_BYTES);
  localparam logic [BW-1:0] IDX_END = BW'(LEN_BYTES - 1);
  localparam logic [6:0]    MAX_T   = 7'(MAX_RECORD);

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_PAD, S_HDR, S_PEMIT, S_CMD, S_HRD, S_HCAP,
    S_CALC, S_UPD, S_DRD, S_DEMIT, S_ONE
  } state_e;

  state_e        state_q;
  cmd_t          cmd_q;
  logic [TW-1:0] top_q;
  logic          push_act_q;
  logic          push_rej_q;
  logic [TW-1:0] push_base_q;
  logic [6:0]    push_len_q;
  logic [6:0]    push_off_q;
  logic [BW-1:0] idx_q;
  logic [LW-1:0] len_q;
  logic [6:0]    n_q;
  logic [6:0]    i_q;
  logic [SW-1:0] nt_q;
  logic [XW-1:0] rd_base_q;
  status_e       status_q;
  logic          out_valid_q;
  res_t          out_q;

  logic [7:0]    mem [STACK_BYTES];
  logic [7:0]    rd_q;
  logic          rd_ok_q;
  logic [7:0]    rd_byte;

  logic          out_free;
  logic          out_load;
  logic          we;
  logic [TW-1:0] waddr;
  logic [7:0]    wdata;
  logic          rd_req;
  logic [XW-1:0] raddr;
  logic          rd_in_range;
  logic [6:0]    n_d;
  logic          top_empty;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign out_load    = out_free && (((state_q == S_PUSH) && push_act_q &&
                                     !(cmd_q.last_byte && !push_rej_q)) ||
                                    (state_q == S_PEMIT) || (state_q == S_DEMIT) ||
                                    (state_q == S_ONE));
  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign rd_byte     = rd_ok_q ? rd_q : 8'd0;
  assign rd_in_range = (raddr < XW'(STACK_BYTES));
  assign top_empty   = (top_q == STACK_T);

  always_comb begin
    we     = 1'b0;
    waddr  = push_base_q + TW'(push_off_q);
    wdata  = cmd_q.data_byte;
    rd_req = 1'b0;
    raddr  = XW'(top_q) + XW'(idx_q);
    unique case (state_q)
      S_PUSH: begin
        we = push_act_q && !push_rej_q && (push_off_q < push_len_q) &&
             (cmd_q.last_byte || out_free);
      end
      S_PAD: begin
        we    = (push_off_q < push_len_q);
        wdata = 8'd0;
      end
      S_HDR: begin
        we    = 1'b1;
        waddr = push_base_q - LEN_T + TW'(idx_q);
        wdata = (idx_q == BW'(0)) ? {1'b0, push_len_q} : 8'd0;
      end
      S_HRD: begin
        rd_req = 1'b1;
      end
      S_DRD: begin
        rd_req = 1'b1;
        raddr  = rd_base_q + XW'(i_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    n_d = cmd_q.want_bytes;
    if (len_q < LW'(cmd_q.want_bytes)) begin
      n_d = len_q[6:0];
    end
    if (n_d > MAX_T) begin
      n_d = MAX_T;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (rd_req) begin
      rd_ok_q <= rd_in_range;
    end
    if (rd_req && rd_in_range) begin
      rd_q <= mem[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= STACK_T;
      push_act_q  <= 1'b0;
      push_rej_q  <= 1'b0;
      push_off_q  <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= (cmd_i.op == OP_PUSH) ? S_PUSH : S_CMD;
          end
        end
        S_PUSH: begin
          if (!push_act_q) begin
            push_act_q <= 1'b1;
            push_off_q <= 7'd0;
            push_len_q <= cmd_q.record_length;
            if ((cmd_q.record_length > MAX_T) ||
                (XW'(top_q) < XW'(cmd_q.record_length) + XW'(LEN_BYTES))) begin
              push_rej_q <= 1'b1;
            end else begin
              push_rej_q  <= 1'b0;
              push_base_q <= top_q - TW'(cmd_q.record_length);
            end
          end else if (cmd_q.last_byte && !push_rej_q) begin
            if (we) begin
              push_off_q <= push_off_q + 7'd1;
            end
            state_q <= S_PAD;
          end else if (out_free) begin
            if (we) begin
              push_off_q <= push_off_q + 7'd1;
            end
            out_q.status      <= push_rej_q ? ST_FULL : ST_PUSHED;
            out_q.out_byte    <= 8'd0;
            out_q.byte_valid  <= 1'b0;
            out_q.last_out    <= 1'b1;
            out_q.stack_empty <= top_empty;
            if (cmd_q.last_byte) begin
              push_act_q <= 1'b0;
              push_rej_q <= 1'b0;
              push_off_q <= 7'd0;
            end
            state_q <= S_IDLE;
          end
        end
        S_PAD: begin
          if (push_off_q < push_len_q) begin
            push_off_q <= push_off_q + 7'd1;
          end else begin
            idx_q   <= BW'(0);
            state_q <= S_HDR;
          end
        end
        S_HDR: begin
          if (idx_q == IDX_END) begin
            top_q   <= push_base_q - LEN_T;
            state_q <= S_PEMIT;
          end else begin
            idx_q <= idx_q + BW'(1);
          end
        end
        S_PEMIT: begin
          if (out_free) begin
            out_q.status      <= ST_PUSHED;
            out_q.out_byte    <= 8'd0;
            out_q.byte_valid  <= 1'b0;
            out_q.last_out    <= 1'b1;
            out_q.stack_empty <= top_empty;
            push_act_q        <= 1'b0;
            push_rej_q        <= 1'b0;
            push_off_q        <= 7'd0;
            state_q           <= S_IDLE;
          end
        end
        S_CMD: begin
          push_act_q <= 1'b0;
          push_rej_q <= 1'b0;
          push_off_q <= 7'd0;
          if (cmd_q.op == OP_CLEAR) begin
            top_q    <= STACK_T;
            status_q <= ST_CLEARED;
            state_q  <= S_ONE;
          end else if (top_q >= STACK_T) begin
            top_q    <= STACK_T;
            status_q <= ST_EMPTY;
            state_q  <= S_ONE;
          end else begin
            status_q  <= (cmd_q.op == OP_PEEK) ? ST_PEEKED : ST_POPPED;
            idx_q     <= BW'(0);
            len_q     <= '0;
            rd_base_q <= XW'(top_q) + XW'(LEN_BYTES);
            state_q   <= S_HRD;
          end
        end
        S_HRD: begin
          state_q <= S_HCAP;
        end
        S_HCAP: begin
          len_q <= len_q | (LW'(rd_byte) << (8 * idx_q));
          if (idx_q == IDX_END) begin
            state_q <= S_CALC;
          end else begin
            idx_q   <= idx_q + BW'(1);
            state_q <= S_HRD;
          end
        end
        S_CALC: begin
          nt_q    <= SW'(top_q) + SW'(LEN_BYTES) + SW'(len_q);
          n_q     <= n_d;
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (cmd_q.op == OP_POP) begin
            top_q <= (nt_q > SW'(STACK_BYTES)) ? STACK_T : nt_q[TW-1:0];
          end
          if (n_q == 7'd0) begin
            state_q <= S_ONE;
          end else begin
            i_q     <= 7'd0;
            state_q <= S_DRD;
          end
        end
        S_DRD: begin
          state_q <= S_DEMIT;
        end
        S_DEMIT: begin
          if (out_free) begin
            out_q.status      <= status_q;
            out_q.out_byte    <= rd_byte;
            out_q.byte_valid  <= 1'b1;
            out_q.last_out    <= (i_q == n_q - 7'd1);
            out_q.stack_empty <= top_empty;
            if (i_q == n_q - 7'd1) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + 7'd1;
              state_q <= S_DRD;
            end
          end
        end
        S_ONE: begin
          if (out_free) begin
            out_q.status      <= status_q;
            out_q.out_byte    <= 8'd0;
            out_q.byte_valid  <= 1'b0;
            out_q.last_out    <= 1'b1;
            out_q.stack_empty <= top_empty;
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.out_byte    = out_q.out_byte;
  assign rsp_o.byte_valid  = out_q.byte_valid;
  assign rsp_o.last_out    = out_q.last_out;
  assign rsp_o.stack_empty = out_q.stack_empty;

  `VRS_ASSERT(a_top_bound, top_q <= STACK_T, "stack top beyond store size")
  `VRS_ASSERT(a_write_live, we |-> (push_act_q && !push_rej_q), "store write outside a live push")
  `VRS_ASSERT(a_offset_bound, (push_act_q && !push_rej_q) |-> (push_off_q <= push_len_q), "push offset past record length")
  `VRS_ASSERT_NEXT(a_pop_frees, (state_q == S_UPD) && (cmd_q.op == OP_POP), top_q > $past(top_q), "pop did not free space")
endmodule
`default_nettype wire

### rtl/variable_record_stack.sv
// Top level of the variable-length record stack.
//
//  channel | role    | transaction carries
//  req_i   | sink    | kind, data_byte, record_length, last_byte, want_bytes
//  rsp_o   | source  | status, out_byte, byte_valid, last_out, stack_empty
//
// In the back-end sequencer a push byte passes the idle and push states; the first
// byte of a record adds a space check, and the last byte of a stored record goes on
// to pad the record with zero bytes, write the LEN_BYTES header bytes and hand off.
// Peek and pop read the header and then each returned byte one at a time through the
// single read port of the byte store, and emit one result with no byte when none is
// returned; clear and an empty peek or pop emit one result. Reset empties the stack
// at once; the store is undefined. A stalled rsp_o holds the back end while the front
// register and the two-entry queue keep taking request transactions until they fill.
`default_nettype none
module variable_record_stack #(
  parameter int STACK_BYTES = 1024,
  parameter int LEN_BYTES   = 4,
  parameter int MAX_RECORD  = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vrs_req_if.sink   req_i,
  vrs_rsp_if.source rsp_o
);
  import vrs_pkg::*;

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t queue_cmd;
  logic queue_valid;
  logic queue_pop;

  vrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  vrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_cmd_o    (queue_cmd),
    .pop_valid_o  (queue_valid),
    .pop_i        (queue_pop)
  );

  vrs_back #(
    .STACK_BYTES (STACK_BYTES),
    .LEN_BYTES   (LEN_BYTES),
    .MAX_RECORD  (MAX_RECORD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (queue_valid),
    .cmd_pop_o   (queue_pop),
    .rsp_o       (rsp_o)
  );
endmodule
`default_nettype wire
